// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic form: explicit clock and active-low reset.
`define KCD_ASSERT_CR(lbl, clk_i, rstn_i, prop) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) prop) \
		else $error("keyword cipher check failed");

// Usual form: the block's own clock and reset.
`define KCD_ASSERT(lbl, prop) `KCD_ASSERT_CR(lbl, clk, arst_n, prop)

`endif

// ===== rtl/kcd_pkg.sv =====
package kcd_pkg;

	localparam int unsigned LETTER_COUNT = 26;
	localparam int unsigned POS_W        = 5;
	localparam logic [7:0]  FIRST_LETTER = 8'd65;
	localparam logic [7:0]  SPACE_CHAR   = 8'd32;

	typedef enum logic [1:0] {
		MODE_KEY     = 2'd0,
		MODE_FINISH  = 2'd1,
		MODE_DECRYPT = 2'd2,
		MODE_UNUSED  = 2'd3
	} mode_t;

	// Broadcast from the top level to every cell.
	typedef struct packed {
		logic               clear;   // start of a new keyword
		logic               pos_ok;  // a free position remains
		logic [POS_W-1:0]   pos;     // position handed to a taking cell
	} cell_ctrl_t;

	// What each cell reports back.
	typedef struct packed {
		logic               used;
		logic               took;
		logic               token;
	} cell_stat_t;

endpackage

// ===== rtl/kcd_cell.sv =====
module kcd_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  kcd_pkg::cell_ctrl_t        ctrl,
	input  logic                       kw_hit,
	input  logic                       token_in,
	output kcd_pkg::cell_stat_t        stat,
	output logic [kcd_pkg::POS_W-1:0]  pos
);

	logic                      used_q;
	logic                      token_q;
	logic [kcd_pkg::POS_W-1:0] pos_q;
	logic                      used_eff;
	logic                      take;

	// A clear by a new keyword wins over the stored bit in the same cycle.
	assign used_eff = used_q & ~ctrl.clear;
	assign take     = (kw_hit | token_q) & ~used_eff & ctrl.pos_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= 1'b0;
			token_q <= 1'b0;
		end else begin
			used_q  <= used_eff | take;
			token_q <= token_in;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pos_q <= ctrl.pos;
		end
	end

	assign stat.used  = used_q;
	assign stat.took  = take;
	assign stat.token = token_q;
	assign pos        = pos_q;

endmodule

// ===== rtl/keyword_cipher_decrypt_core.sv =====
// Keyword substitution cipher decoder.
// Request channel: req_valid / req_stall with mode and char_code. Mode 0 adds
// a keyword character, mode 1 completes the mixed alphabet, mode 2 decrypts a
// ciphertext letter. Mode 3, non-letter decrypts and decrypts before the key is
// complete are taken and dropped.
// Result channel: result_valid / result_stall with plain_char, one result
// per decrypted letter, in request order.
// A decrypt result is registered and shown in the cycle after its request is taken.
// Throughput: keyword and decrypt requests go at one per cycle while no result
// is held by result_stall. A finish request sends a token down the row of 26
// letter cells, one cell a cycle, and req_stall is high while it is in the row.
// Reset clears the key (no letters used, not ready) and result_valid;
// stored positions are rewritten before they are read.
// While result_stall holds a result, req_stall is high and the result stays.
module keyword_cipher_decrypt_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  logic [1:0] mode,
	input  logic [7:0] char_code,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [6:0] plain_char
);

	localparam int unsigned N = kcd_pkg::LETTER_COUNT;
	localparam int unsigned W = kcd_pkg::POS_W;

	logic                 accept;
	logic                 is_letter;
	logic [W-1:0]         idx;
	logic [W-1:0]         next_pos_q;
	logic                 key_ready_q;
	logic                 result_valid_q;
	logic [6:0]           plain_char_q;
	logic                 busy;
	logic                 any_took;
	logic                 do_key;
	logic                 do_fin;
	logic                 do_dec;
	logic [N:0]           tok;
	logic [N-1:0]         took_v;
	logic [W-1:0]         pos_a [N];
	logic [W-1:0]         rd_pos;
	kcd_pkg::cell_ctrl_t  ctrl;
	kcd_pkg::cell_stat_t  stat_a [N];

	assign busy      = |tok[N:1];
	assign req_stall = busy | (result_valid_q & result_stall);
	assign accept    = req_valid & ~req_stall;

	assign is_letter = (char_code >= kcd_pkg::FIRST_LETTER) &&
		(char_code < kcd_pkg::FIRST_LETTER + 8'(N));
	assign idx       = W'(char_code - kcd_pkg::FIRST_LETTER);

	assign do_key = accept && (mode == kcd_pkg::MODE_KEY);
	assign do_fin = accept && (mode == kcd_pkg::MODE_FINISH);
	assign do_dec = accept && (mode == kcd_pkg::MODE_DECRYPT) && key_ready_q && is_letter;

	// A keyword after a complete key restarts from position zero.
	assign ctrl.clear  = do_key & key_ready_q;
	assign ctrl.pos    = ctrl.clear ? '0 : next_pos_q;
	assign ctrl.pos_ok = ctrl.pos < W'(N);

	assign tok[0] = do_fin;

	genvar g;
	generate
		for (g = 0; g < N; g++) begin : g_cell
			kcd_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (ctrl),
				.kw_hit   (do_key && is_letter && (idx == W'(g))),
				.token_in (tok[g]),
				.stat     (stat_a[g]),
				.pos      (pos_a[g])
			);
			assign tok[g+1]  = stat_a[g].token;
			assign took_v[g] = stat_a[g].took & stat_a[g].used | stat_a[g].took;
		end
	endgenerate

	assign any_took = |took_v;

	always_comb begin
		rd_pos = '0;
		if (is_letter) begin
			rd_pos = pos_a[idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_pos_q  <= '0;
			key_ready_q <= 1'b0;
		end else begin
			if (ctrl.clear || any_took) begin
				next_pos_q <= ctrl.pos + W'(any_took);
			end
			if (do_key) begin
				key_ready_q <= 1'b0;
			end else if (tok[N]) begin
				key_ready_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (do_dec) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_dec) begin
			plain_char_q <= kcd_pkg::FIRST_LETTER[6:0] + 7'(rd_pos);
		end
	end

	assign result_valid = result_valid_q;
	assign plain_char   = plain_char_q;

endmodule

// ===== rtl/kcd_checker.sv =====
`include "assert_macros.svh"

module kcd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_stall,
	input logic [1:0] mode,
	input logic       result_valid,
	input logic       result_stall,
	input logic [6:0] plain_char
);

	logic req_take;
	logic res_held;

	assign req_take = req_valid & ~req_stall;
	assign res_held = result_valid & result_stall;

	`KCD_ASSERT(a_res_hold, res_held |=> result_valid)
	`KCD_ASSERT(a_res_stable, res_held |=> $stable(plain_char))
	`KCD_ASSERT(a_res_letter, result_valid |-> (plain_char >= 7'd65) && (plain_char <= 7'd90))
	`KCD_ASSERT(a_finish_busy, (req_take && (mode == kcd_pkg::MODE_FINISH)) |=> req_stall)
	`KCD_ASSERT(a_key_silent, (req_take && (mode == kcd_pkg::MODE_KEY) && !res_held) |=> !result_valid)

endmodule

bind keyword_cipher_decrypt_core kcd_checker u_kcd_checker (.*);
